>>> hw/rtl/read_coverage_accumulator_core_defines.svh
// Assertion macros shared by the coverage accumulator RTL.
// Expands to concurrent assertions in simulation and to nothing in synthesis.
`ifndef READ_COVERAGE_ACCUMULATOR_CORE_DEFINES_SVH
`define READ_COVERAGE_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property, sampled on clk, off during reset.
`define RCACC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define RCACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RCACC_ASSERT(lbl, prop, msg)
`define RCACC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/rcacc_pkg.sv
// Shared types, codes and constants of the read coverage accumulator.
// No dependencies; used by rcacc_store and read_coverage_accumulator_core.
package rcacc_pkg;

  localparam int POSITIONS_DEF  = 65536;
  localparam int COUNT_BITS_DEF = 16;

  localparam int POS_W = 31;
  localparam int SYM_W = 8;
  localparam int LEN_W = 16;
  localparam int CNT_W = 16;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  // op codes
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_CIGAR = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] STAT_OK  = 2'd0;
  localparam logic [ST_W-1:0] STAT_OOW = 2'd1;
  localparam logic [ST_W-1:0] STAT_BAD = 2'd2;

  // CIGAR characters
  localparam logic [SYM_W-1:0] CH_0 = 8'h30;
  localparam logic [SYM_W-1:0] CH_9 = 8'h39;
  localparam logic [SYM_W-1:0] CH_M = 8'h4D;
  localparam logic [SYM_W-1:0] CH_N = 8'h4E;

  localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;
  } rcacc_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] coverage_count;
    logic [ST_W-1:0]  status;
  } rcacc_out_t;

  // Store request: rd = read slot, inc = read slot and write back +1.
  typedef struct packed {
    logic rd;
    logic inc;
  } rcacc_store_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_QUERY,
    ST_FINISH
  } rcacc_state_t;

endpackage

>>> hw/rtl/rcacc_store.sv
// Coverage counter memory: clearing sweep after reset, registered read,
// saturating read-modify-write increment. Depends on rcacc_pkg.
module rcacc_store #(
  parameter int POSITIONS  = rcacc_pkg::POSITIONS_DEF,
  parameter int COUNT_BITS = rcacc_pkg::COUNT_BITS_DEF,
  parameter int SLOT_W     = $clog2(POSITIONS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rcacc_pkg::rcacc_store_ctl_t ctl,
  input  logic [SLOT_W-1:0]           slot,
  output logic                        clr_busy,
  output logic [COUNT_BITS-1:0]       rd_data
);
  import rcacc_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POSITIONS - 1);

  logic [COUNT_BITS-1:0] mem [POSITIONS];

  logic                  clr_busy_r;
  logic [SLOT_W-1:0]     clr_addr_r;
  logic                  inc_pend_r;
  logic [SLOT_W-1:0]     inc_slot_r;
  logic [COUNT_BITS-1:0] rd_q_r;
  logic [COUNT_BITS-1:0] inc_val;

  // saturating increment of the word read last cycle
  assign inc_val = (rd_q_r == {COUNT_BITS{1'b1}}) ? rd_q_r : rd_q_r + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      inc_pend_r <= 1'b0;
    end else begin
      inc_pend_r <= ctl.inc;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + SLOT_W'(1);
        if (clr_addr_r == LAST_SLOT) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    inc_slot_r <= slot;
  end

  // single write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (inc_pend_r) begin
      mem[inc_slot_r] <= inc_val;
    end
    if (ctl.rd || ctl.inc) begin
      rd_q_r <= mem[slot];
    end
  end

  assign clr_busy = clr_busy_r;
  assign rd_data  = rd_q_r;

endmodule

>>> hw/rtl/read_coverage_accumulator_core.sv
// Read coverage accumulator: builds a per-position coverage histogram from
// begin / CIGAR-character / query beats and answers every input beat with
// exactly one result beat. The counters live in one memory with a single
// write port and one registered read port, POSITIONS words (COUNT_BITS each),
// position window_base + k at word k. After reset a clearing pass zeroes the
// memory, one word per cycle, and the block stalls its input until every word
// is cleared (65536 words by default); config writes are taken throughout.
// Each item holds the input stalled until it returns to idle: begin, digit,
// 'N', bad characters and unused ops go straight to the finish step; a query
// first passes a memory-read step; an 'M' with pending length L walks L bases,
// issuing one read-modify-write per base through the memory's ports
// (read this cycle, saturating write-back the next). Window checks and the
// cursor advance run alongside the walk. A result waiting on out_stall does
// not hold up the next accept; only the hand-off from the finish step waits
// for the output register to free up.
module read_coverage_accumulator_core #(
  parameter int POSITIONS  = rcacc_pkg::POSITIONS_DEF,
  parameter int COUNT_BITS = rcacc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rcacc_pkg::rcacc_in_t             in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output rcacc_pkg::rcacc_out_t            out_data,
  // window_base write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcacc_pkg::POS_W-1:0]      cfg_data
);
  import rcacc_pkg::*;

  localparam int          SLOT_W  = $clog2(POSITIONS);
  localparam logic [31:0] POS_LIM = 32'(POSITIONS);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  rcacc_state_t      state_r, state_nxt;
  logic [POS_W-1:0]  window_base_r;
  logic [POS_W-1:0]  cursor_r, cursor_nxt;
  logic [LEN_W-1:0]  pend_r, pend_nxt;        // length being built from digits
  logic [LEN_W-1:0]  remain_r, remain_nxt;    // bases left in the 'M' walk
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic [CNT_W-1:0]  res_count_r, res_count_nxt;
  logic              q_hit_r, q_hit_nxt;
  logic              out_valid_r;
  rcacc_out_t        out_r;

  // ---------------------------------------------------------------------
  // Store interface
  // ---------------------------------------------------------------------
  rcacc_store_ctl_t      store_ctl;
  logic [SLOT_W-1:0]     store_slot;
  logic                  clr_busy;
  logic [COUNT_BITS-1:0] rd_data;

  rcacc_store #(
    .POSITIONS  (POSITIONS),
    .COUNT_BITS (COUNT_BITS),
    .SLOT_W     (SLOT_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (store_ctl),
    .slot     (store_slot),
    .clr_busy (clr_busy),
    .rd_data  (rd_data)
  );

  // ---------------------------------------------------------------------
  // Window checks: one for the walking cursor, one for the query position
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] walk_diff, qry_diff;
  logic             walk_hit, qry_hit;

  assign walk_diff = cursor_r - window_base_r;
  assign qry_diff  = in_data.position - window_base_r;
  assign walk_hit  = (cursor_r >= window_base_r) && ({1'b0, walk_diff} < POS_LIM);
  assign qry_hit   = (in_data.position >= window_base_r) && ({1'b0, qry_diff} < POS_LIM);

  // digit accumulation: pend * 10 + digit, saturated to 16 bits
  logic [19:0] dig_acc;
  logic        is_digit;
  assign dig_acc  = 20'(pend_r) * 20'd10 + 20'(in_data.symbol - CH_0);
  assign is_digit = (in_data.symbol >= CH_0) && (in_data.symbol <= CH_9);

  // read count clipped to the 16-bit result field
  logic [31:0]      rd_ext;
  logic [CNT_W-1:0] rd_clip;
  assign rd_ext  = 32'(rd_data);
  assign rd_clip = (rd_ext > 32'(CNT_MAX)) ? CNT_MAX : rd_ext[CNT_W-1:0];

  logic in_acc, out_free;
  assign in_stall = (state_r != ST_IDLE) || clr_busy;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    pend_nxt       = pend_r;
    remain_nxt     = remain_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    q_hit_nxt      = q_hit_r;
    store_ctl      = '0;
    store_slot     = qry_diff[SLOT_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_status_nxt = STAT_OK;
          res_count_nxt  = '0;
          state_nxt      = ST_FINISH;
          case (in_data.op)
            OP_BEGIN: begin
              cursor_nxt = in_data.position;
              pend_nxt   = '0;
            end
            OP_CIGAR: begin
              if (is_digit) begin
                pend_nxt = (dig_acc > 20'(LEN_MAX)) ? LEN_MAX : dig_acc[LEN_W-1:0];
              end else if (in_data.symbol == CH_M) begin
                pend_nxt   = '0;
                remain_nxt = pend_r;
                if (pend_r != '0) begin
                  state_nxt = ST_WALK;
                end
              end else if (in_data.symbol == CH_N) begin
                pend_nxt   = '0;
                cursor_nxt = cursor_r + POS_W'(pend_r);
              end else begin
                res_status_nxt = STAT_BAD;
              end
            end
            OP_QUERY: begin
              q_hit_nxt    = qry_hit;
              store_ctl.rd = qry_hit;
              state_nxt    = ST_QUERY;
              if (!qry_hit) begin
                res_status_nxt = STAT_OOW;
              end
            end
            default: begin
              res_status_nxt = STAT_BAD;
            end
          endcase
        end
      end

      // one base per cycle; out-of-window bases are skipped and flagged
      ST_WALK: begin
        store_slot    = walk_diff[SLOT_W-1:0];
        store_ctl.inc = walk_hit;
        if (!walk_hit) begin
          res_status_nxt = STAT_OOW;
        end
        cursor_nxt = cursor_r + POS_W'(1);
        remain_nxt = remain_r - LEN_W'(1);
        if (remain_r == LEN_W'(1)) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_QUERY: begin
        res_count_nxt = q_hit_r ? rd_clip : '0;
        state_nxt     = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_base_r <= '0;
      cursor_r      <= '0;
      pend_r        <= '0;
      remain_r      <= '0;
      q_hit_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      pend_r   <= pend_nxt;
      remain_r <= remain_nxt;
      q_hit_r  <= q_hit_nxt;
      if (cfg_valid) begin
        window_base_r <= cfg_data;
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    if (state_r == ST_FINISH && out_free) begin
      out_r.coverage_count <= res_count_r;
      out_r.status         <= res_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "read_coverage_accumulator_core_defines.svh"

  `RCACC_ASSERT(a_no_accept_busy, !(in_acc && clr_busy),
                "item accepted during clear pass")
  `RCACC_ASSERT(a_inc_only_walk, !store_ctl.inc || (state_r == ST_WALK),
                "increment outside walk")
  `RCACC_ASSERT_NEXT(a_walk_ends, (state_r == ST_WALK) && (remain_r == LEN_W'(1)),
                     state_r == ST_FINISH, "walk overran its length")
  `RCACC_ASSERT_NEXT(a_query_one, state_r == ST_QUERY, state_r == ST_FINISH,
                     "query did not finish")

endmodule
